[hw/rtl/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and codes for the ring buffer deque: word layouts, action and
// status codes, controller state and the controller/datapath link.
// ----------------------------------------------------------------------------
package rbd_pkg;

  // field widths
  localparam int DATA_W   = 32;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ_FRONT = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_READ_BACK  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // request word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   push_data;
  } req_word_t;

  // response word
  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  item_count;
    logic                is_empty;
    logic                is_full;
  } rsp_word_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_READ
  } rbd_state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic apply;        // take the request, update indices and store
    logic load_result;  // load response register from the request decode
    logic load_read;    // load response register from store read data
    logic cfg_write;    // write capacity and empty the deque
  } rbd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic out_free;     // response register can take a word this cycle
    logic rd_hit;       // current request is a read of a non-empty deque
  } rbd_stat_t;

endpackage

[hw/rtl/rbd_ram.sv]
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/rbd_ctrl.sv]
// ----------------------------------------------------------------------------
// rbd_ctrl
// Request sequencer: accepts a request when the response register is free
// and no capacity write is offered, and waits in S_READ on the registered
// store read for successful read actions.
// ----------------------------------------------------------------------------
module rbd_ctrl
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  rbd_stat_t stat,
  output rbd_cmd_t  cmd
);

  rbd_state_t state, state_next;
  logic       accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands; a capacity write holds off requests
  always_comb begin
    state_next      = state;
    req_stall       = 1'b1;
    cfg_ready       = 1'b0;
    accept          = 1'b0;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        req_stall       = !stat.out_free || cfg_valid;
        cfg_ready       = 1'b1;
        accept          = req_valid && stat.out_free && !cfg_valid;
        cmd.apply       = accept;
        cmd.load_result = accept && !stat.rd_hit;
        cmd.cfg_write   = cfg_valid;
        if (accept && stat.rd_hit) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.load_read = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/rbd_datapath.sv]
// ----------------------------------------------------------------------------
// rbd_datapath
// Head/tail/count registers, capacity register, element store and the
// response register.
// ----------------------------------------------------------------------------
module rbd_datapath
  import rbd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  rbd_cmd_t           cmd,
  output rbd_stat_t          stat,
  input  req_word_t          req,
  input  logic [COUNT_W-1:0] cfg_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_word_t          rsp
);

  localparam int IW      = $clog2(DEPTH);
  localparam int CW      = ((IW > COUNT_W) ? IW : COUNT_W) + 1;
  localparam int CapMax  = (DEPTH < 31) ? DEPTH : 31;
  localparam int CapRst  = (DEPTH < 16) ? DEPTH : 16;

  logic [COUNT_W-1:0]  cap;
  logic [COUNT_W-1:0]  count, count_next;
  logic [IW-1:0]       head, head_next;
  logic [IW-1:0]       tail, tail_next;
  logic [COUNT_W-1:0]  cap_wr;
  logic                full, empty;
  logic [IW-1:0]       head_inc, head_dec, tail_inc, tail_dec;
  logic [STATUS_W-1:0] st;
  logic                we, re;
  logic [IW-1:0]       waddr, raddr;
  logic [DATA_W-1:0]   ram_rdata;

  // index stepping, wrapping at capacity
  assign head_inc = (CW'(head) + CW'(1) >= CW'(cap)) ? '0 : head + IW'(1);
  assign tail_inc = (CW'(tail) + CW'(1) >= CW'(cap)) ? '0 : tail + IW'(1);
  assign head_dec = (head == '0) ? IW'(cap - COUNT_W'(1)) : head - IW'(1);
  assign tail_dec = (tail == '0) ? IW'(cap - COUNT_W'(1)) : tail - IW'(1);

  assign full  = count >= cap;
  assign empty = count == '0;

  // request decode
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    st         = ST_OK;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = tail;
    raddr      = head;
    case (req.action)
      ACT_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          waddr      = tail;
          tail_next  = tail_inc;
          count_next = count + COUNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          we         = 1'b1;
          waddr      = head_dec;
          head_next  = head_dec;
          count_next = count + COUNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          tail_next  = tail_dec;
          count_next = count - COUNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = count - COUNT_W'(1);
        end
      end
      ACT_READ_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = head;
        end
      end
      ACT_READ_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = tail_dec;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.rd_hit   = re;
  assign stat.out_free = !rsp_valid || !rsp_stall;

  // capacity clamp: zero reads as one, above the store size as the store size
  assign cap_wr = (cfg_data == '0) ? COUNT_W'(1) :
                  (cfg_data > COUNT_W'(CapMax)) ? COUNT_W'(CapMax) : cfg_data;

  // deque state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= COUNT_W'(CapRst);
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.cfg_write) begin
      cap   <= cap_wr;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.apply) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // element store
  rbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.apply && we),
    .waddr (waddr),
    .wdata (req.push_data),
    .re    (cmd.apply && re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // response valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result || cmd.load_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // response word; a read leaves the count unchanged
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp.read_data  <= '0;
      rsp.status     <= st;
      rsp.item_count <= count_next;
      rsp.is_empty   <= count_next == '0;
      rsp.is_full    <= count_next == cap;
    end else if (cmd.load_read) begin
      rsp.read_data  <= ram_rdata;
      rsp.status     <= ST_OK;
      rsp.item_count <= count;
      rsp.is_empty   <= count == '0;
      rsp.is_full    <= count == cap;
    end
  end

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("count above capacity");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(head) < CW'(cap))
    else $error("head index out of range");

  a_tail_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(tail) < CW'(cap))
    else $error("tail index out of range");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.apply && !cmd.cfg_write && we |=> count == $past(count) + COUNT_W'(1))
    else $error("accepted push did not bump count");
`endif

endmodule

[hw/rtl/ring_buffer_deque.sv]
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue in a circular store with head, tail and count, and a
// capacity register that sets the wrap point of both indices.
// ----------------------------------------------------------------------------
//  channel  | signals                       | moves
//  ---------+-------------------------------+--------------------------------
//  req      | req_valid, req_stall, req     | action and push word
//  rsp      | rsp_valid, rsp_stall, rsp     | data, status, count, flags
//  cfg      | cfg_valid, cfg_ready, cfg_data| capacity_limit word
//
//  Pushes, pops and rejected requests load the response word from the request
//  decode, and a new request can follow unless rsp_stall holds the response word.
//  A successful read waits on the registered read port of the element store.
//  Reset is synchronous: capacity returns to 16 (or DEPTH if smaller), the
//  deque is empty, the store is not cleared.
//  req_stall is high while a read waits on the store, while a response
//  word is held by rsp_stall, or while a capacity write is offered.
// ----------------------------------------------------------------------------
module ring_buffer_deque
  import rbd_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_word_t          req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rsp_word_t          rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  rbd_cmd_t  cmd;
  rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
